// ===== rtl/core/acs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int StoreW      = 16;
  localparam int PctW        = 7;
  localparam int FuncW       = 2;
  localparam int NumW        = StoreW + PctW;
  localparam int FullScale   = 100;
  localparam int StoreMax    = 65535;
  localparam int QueueDepth  = 2;
  localparam int DefChannels = 5;
  localparam int DefAdcBits  = 10;
  localparam int DefChanW    = 3;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_LEARN   = 2'd1,
    FUNC_CONVERT = 2'd2
  } func_e;

endpackage

`default_nettype wire

// ===== rtl/core/acs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acs_in_if #(
  parameter int CHAN_W   = acs_pkg::DefChanW,
  parameter int ADC_BITS = acs_pkg::DefAdcBits
);
  logic                      valid;
  logic                      ready;
  logic [acs_pkg::FuncW-1:0] func;
  logic [CHAN_W-1:0]         channel;
  logic [ADC_BITS-1:0]       sample;

  modport source (output valid, output func, output channel, output sample, input ready);
  modport sink   (input valid, input func, input channel, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/acs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acs_out_if;
  logic                       valid;
  logic                       ready;
  logic [acs_pkg::PctW-1:0]   percent;
  logic                       degenerate;
  logic [acs_pkg::StoreW-1:0] low_bound;
  logic [acs_pkg::StoreW-1:0] high_bound;

  modport source (output valid, output percent, output degenerate, output low_bound,
                  output high_bound, input ready);
  modport sink   (input valid, input percent, input degenerate, input low_bound,
                  input high_bound, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/adc_range_calibrate_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Learned minimum and maximum per ADC channel, with scaling of samples to a percentage.
// Commands arrive on in_i (func, channel, sample); a clear resets every bound, a learn
// widens one channel's bounds and a convert returns one beat on out_o with the percent
// position of the clamped sample, a degenerate flag and the stored bounds.
// Learn and convert beats for a channel beyond the last one, and the unused func code,
// are taken and dropped; only convert gives an output beat.
// A two-entry queue sits between the accepting front and the executing back end, so input
// beats are taken while a conversion runs or while out_o is stalled, until the queue fills.
// A convert passes from the queue through a setup state, a multiply state and seven restoring
// divider steps, then the output register. The back end takes no new command while a
// conversion runs and completes a learn or clear as it accepts it, so the divider sets the
// sustained rate. A stalled output beat holds the back end in its final state until
// out_o.ready is seen.
// Reset sets every minimum to zero and every maximum to full scale of the ADC, empties the
// queue and drops any pending output beat.
module adc_range_calibrate_scale #(
  parameter int CHANNELS = acs_pkg::DefChannels,
  parameter int ADC_BITS = acs_pkg::DefAdcBits
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  acs_in_if.sink   in_i,
  acs_out_if.source out_o
);

  localparam int ChanW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                cmd_valid, cmd_ready;
  acs_pkg::func_e      cmd_op;
  logic [ChanW-1:0]    cmd_chan;
  logic [ADC_BITS-1:0] cmd_sample;

  acs_front #(
    .CHANNELS(CHANNELS),
    .ADC_BITS(ADC_BITS),
    .CHAN_W  (ChanW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_op_o    (cmd_op),
    .cmd_chan_o  (cmd_chan),
    .cmd_sample_o(cmd_sample),
    .cmd_ready_i (cmd_ready)
  );

  acs_back #(
    .CHANNELS(CHANNELS),
    .ADC_BITS(ADC_BITS),
    .CHAN_W  (ChanW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_op_i    (cmd_op),
    .cmd_chan_i  (cmd_chan),
    .cmd_sample_i(cmd_sample),
    .cmd_ready_o (cmd_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/acs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_front #(
  parameter int CHANNELS = acs_pkg::DefChannels,
  parameter int ADC_BITS = acs_pkg::DefAdcBits,
  parameter int CHAN_W   = acs_pkg::DefChanW
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  acs_in_if.sink                     in_i,
  output      logic                  cmd_valid_o,
  output      acs_pkg::func_e        cmd_op_o,
  output      logic [CHAN_W-1:0]     cmd_chan_o,
  output      logic [ADC_BITS-1:0]   cmd_sample_o,
  input  wire logic                  cmd_ready_i
);

  localparam int Depth = acs_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  acs_pkg::func_e      op_q  [Depth];
  logic [CHAN_W-1:0]   chan_q[Depth];
  logic [ADC_BITS-1:0] smp_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                keep, chan_ok, push, pop;

  assign chan_ok = 32'(in_i.channel) < CHANNELS;

  always_comb begin
    unique case (in_i.func) inside
      acs_pkg::FUNC_CLEAR:                        keep = 1'b1;
      acs_pkg::FUNC_LEARN, acs_pkg::FUNC_CONVERT: keep = chan_ok;
      default:                                    keep = 1'b0;
    endcase
  end

  assign in_i.ready  = cnt_q != CntW'(Depth);
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = cnt_q != '0;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_op_o     = op_q[rptr_q];
  assign cmd_chan_o   = chan_q[rptr_q];
  assign cmd_sample_o = smp_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wptr_q]   <= acs_pkg::func_e'(in_i.func);
      chan_q[wptr_q] <= CHAN_W'(in_i.channel);
      smp_q[wptr_q]  <= ADC_BITS'(in_i.sample);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/acs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_back #(
  parameter int CHANNELS = acs_pkg::DefChannels,
  parameter int ADC_BITS = acs_pkg::DefAdcBits,
  parameter int CHAN_W   = acs_pkg::DefChanW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  input  wire acs_pkg::func_e      cmd_op_i,
  input  wire logic [CHAN_W-1:0]   cmd_chan_i,
  input  wire logic [ADC_BITS-1:0] cmd_sample_i,
  output      logic                cmd_ready_o,
  acs_out_if.source                out_o
);

  localparam int StoreW = acs_pkg::StoreW;
  localparam int PctW   = acs_pkg::PctW;
  localparam int NumW   = acs_pkg::NumW;
  localparam int StepW  = $clog2(PctW);
  localparam logic [StoreW-1:0] AdcTop = StoreW'((32'd1 << ADC_BITS) - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [StoreW-1:0] min_q[CHANNELS];
  logic [StoreW-1:0] max_q[CHANNELS];
  logic [StoreW-1:0] rd_min, rd_max, lo, hi, smp, cur;
  logic [StoreW-1:0] lo_q, hi_q, cur_q, lowb_q, highb_q;
  logic              degen_q;
  logic [NumW-1:0]   rem_q, den_q;
  logic [NumW:0]     trial;
  logic [PctW-1:0]   quo_q;
  logic [StepW-1:0]  step_q;
  logic              pop, out_free;

  logic              out_valid_q;
  logic [PctW-1:0]   pct_o_q;
  logic              degen_o_q;
  logic [StoreW-1:0] lowb_o_q, highb_o_q;

  assign cmd_ready_o = state_q == S_IDLE;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_free    = !out_valid_q || out_o.ready;

  assign rd_min = min_q[cmd_chan_i];
  assign rd_max = max_q[cmd_chan_i];
  assign smp    = StoreW'(cmd_sample_i);

  always_comb begin
    lo = (rd_min > rd_max) ? rd_max : rd_min;
    hi = (rd_min > rd_max) ? rd_min : rd_max;
    if (smp < lo) begin
      cur = lo;
    end else if (smp > hi) begin
      cur = hi;
    end else begin
      cur = smp;
    end
  end

  assign trial = {1'b0, rem_q} - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop && cmd_op_i == acs_pkg::FUNC_CONVERT) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (step_q == StepW'(PctW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        min_q[i] <= '0;
        max_q[i] <= AdcTop;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        case (cmd_op_i)
          acs_pkg::FUNC_CLEAR: begin
            for (int i = 0; i < CHANNELS; i++) begin
              min_q[i] <= StoreW'(acs_pkg::StoreMax);
              max_q[i] <= '0;
            end
          end
          acs_pkg::FUNC_LEARN: begin
            if (smp < rd_min) begin
              min_q[cmd_chan_i] <= smp;
            end
            if (smp > rd_max) begin
              max_q[cmd_chan_i] <= smp;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        lo_q    <= lo;
        hi_q    <= hi;
        cur_q   <= cur;
        lowb_q  <= rd_min;
        highb_q <= rd_max;
        degen_q <= rd_min == rd_max;
        step_q  <= '0;
      end
      S_MUL: begin
        rem_q <= NumW'(cur_q - lo_q) * NumW'(acs_pkg::FullScale);
        den_q <= NumW'(hi_q - lo_q) << (PctW - 1);
      end
      S_DIV: begin
        if (!trial[NumW]) begin
          rem_q <= trial[NumW-1:0];
        end
        quo_q  <= {quo_q[PctW-2:0], !trial[NumW]};
        den_q  <= den_q >> 1;
        step_q <= step_q + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          pct_o_q   <= degen_q ? '0 : quo_q;
          degen_o_q <= degen_q;
          lowb_o_q  <= lowb_q;
          highb_o_q <= highb_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.percent    = pct_o_q;
  assign out_o.degenerate = degen_o_q;
  assign out_o.low_bound  = lowb_o_q;
  assign out_o.high_bound = highb_o_q;

endmodule

`default_nettype wire

// ===== rtl/core/acs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [acs_pkg::PctW-1:0]   percent_i,
  input wire logic                       degenerate_i,
  input wire logic [acs_pkg::StoreW-1:0] low_bound_i,
  input wire logic [acs_pkg::StoreW-1:0] high_bound_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(percent_i) &&
      $stable(degenerate_i) && $stable(low_bound_i) && $stable(high_bound_i))
    else $error("output beat changed while stalled");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> percent_i <= acs_pkg::PctW'(acs_pkg::FullScale))
    else $error("percent above full scale");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |-> percent_i == '0)
    else $error("degenerate beat with non-zero percent");

  a_degen_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> degenerate_i == (low_bound_i == high_bound_i))
    else $error("degenerate flag disagrees with bounds");

endmodule

bind adc_range_calibrate_scale acs_checker u_acs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .percent_i   (out_o.percent),
  .degenerate_i(out_o.degenerate),
  .low_bound_i (out_o.low_bound),
  .high_bound_i(out_o.high_bound)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import acs_pkg::*;

  localparam int NumChannels = DefChannels;
  localparam int AdcBits = DefAdcBits;
  localparam int ChanW = DefChanW;
  localparam logic [FuncW-1:0] FuncSpare = 2'd3;
  localparam logic [AdcBits-1:0] AdcTop = {AdcBits{1'b1}};
  localparam int MaxLoggedMismatches = 10;
  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 200;
  localparam int RandomCommands = 1000;
  localparam int SettleCycles = 24;

  typedef struct packed {
    logic [PctW-1:0]   percent;
    logic              degenerate;
    logic [StoreW-1:0] low_bound;
    logic [StoreW-1:0] high_bound;
  } conversion_t;

  logic clk;
  logic rst_n;

  acs_in_if #(.CHAN_W(ChanW), .ADC_BITS(AdcBits)) cmd_if ();
  acs_out_if conv_if ();

  adc_range_calibrate_scale #(
    .CHANNELS(NumChannels),
    .ADC_BITS(AdcBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (conv_if)
  );

  logic [StoreW-1:0] learned_min [NumChannels];
  logic [StoreW-1:0] learned_max [NumChannels];
  conversion_t expected_conversions [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_off_req = 0;
  int ready_gap = 0;
  bit cmd_idle_on = 1'b1;
  bit conv_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit predict_command(input logic [FuncW-1:0] func,
                                         input logic [ChanW-1:0] chan,
                                         input logic [AdcBits-1:0] smp,
                                         output conversion_t res);
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    res = '0;
    if (func == FUNC_CLEAR) begin
      foreach (learned_min[i]) begin
        learned_min[i] = StoreW'(StoreMax);
        learned_max[i] = '0;
      end
      return 1'b0;
    end
    if (chan >= NumChannels) return 1'b0;
    if (func == FUNC_LEARN) begin
      if (smp < learned_min[chan]) learned_min[chan] = StoreW'(smp);
      if (smp > learned_max[chan]) learned_max[chan] = StoreW'(smp);
      return 1'b0;
    end
    if (func != FUNC_CONVERT) return 1'b0;
    lo = 32'(learned_min[chan]);
    hi = 32'(learned_max[chan]);
    if (lo > hi) begin
      pos = lo;
      lo = hi;
      hi = pos;
    end
    res.low_bound = learned_min[chan];
    res.high_bound = learned_max[chan];
    if (lo == hi) begin
      res.degenerate = 1'b1;
    end else begin
      pos = 32'(smp);
      if (pos < lo) pos = lo;
      else if (pos > hi) pos = hi;
      res.percent = PctW'((FullScale * (pos - lo)) / (hi - lo));
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic int pick_cmd_gap();
    if (!cmd_idle_on || $urandom_range(0, 99) < 60) return 0;
    return pick_gap();
  endfunction

  function automatic logic [AdcBits-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return AdcTop;
    return AdcBits'($urandom_range(0, AdcTop));
  endfunction

  task automatic send_command(input logic [FuncW-1:0] func, input logic [ChanW-1:0] chan,
                              input logic [AdcBits-1:0] smp, input int gap);
    conversion_t res;
    @(negedge clk);
    cmd_if.valid = 1'b1;
    cmd_if.func = func;
    cmd_if.channel = chan;
    cmd_if.sample = smp;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    if (predict_command(func, chan, smp, res)) expected_conversions.push_back(res);
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (expected_conversions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_reset_bounds();
    send_command(FUNC_CONVERT, 0, 0, 0);
    send_command(FUNC_CONVERT, 0, AdcTop, 0);
    send_command(FUNC_CONVERT, 3, 512, 1);
    send_command(FUNC_CONVERT, 4, 1, 0);
    wait_for_drain();
  endtask

  task automatic test_clear_and_scaling();
    send_command(FUNC_CLEAR, 7, AdcTop, 0);
    send_command(FUNC_CONVERT, 2, 512, 0);
    send_command(FUNC_LEARN, 2, 300, 0);
    send_command(FUNC_CONVERT, 2, 300, 0);
    send_command(FUNC_LEARN, 2, 700, 1);
    send_command(FUNC_CONVERT, 2, 0, 0);
    send_command(FUNC_CONVERT, 2, AdcTop, 0);
    send_command(FUNC_CONVERT, 2, 500, 0);
    send_command(FUNC_LEARN, 2, 0, 0);
    send_command(FUNC_LEARN, 2, AdcTop, 0);
    send_command(FUNC_CONVERT, 2, 1, 0);
    send_command(FUNC_CONVERT, 2, AdcTop - 1'b1, 1);
    wait_for_drain();
  endtask

  // After a clear every bound is inverted, so a learn that leaked through would show up.
  task automatic test_ignored_commands();
    send_command(FUNC_CLEAR, 0, 0, 0);
    send_command(FUNC_LEARN, 5, 512, 0);
    send_command(FUNC_LEARN, 6, 512, 0);
    send_command(FUNC_LEARN, 7, AdcTop, 0);
    send_command(FuncSpare, 0, 300, 0);
    send_command(FUNC_CONVERT, 5, 512, 0);
    send_command(FUNC_CONVERT, 0, 512, 0);
    send_command(FUNC_CONVERT, 1, 512, 0);
    send_command(FUNC_CONVERT, 4, AdcTop, 0);
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    hold_off_req = HoldOffCycles;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 0) send_command(FUNC_LEARN, ChanW'(i % NumChannels), rand_sample(), 0);
      send_command(FUNC_CONVERT, ChanW'(i % NumChannels), rand_sample(), 0);
    end
    wait_for_drain();
  endtask

  task automatic test_random_commands();
    int issued;
    int next_toggle;
    int r;
    int ch;
    issued = 0;
    next_toggle = 0;
    while (issued < RandomCommands) begin
      if (issued >= next_toggle) begin
        cmd_idle_on = ($urandom_range(0, 3) != 0);
        conv_idle_on = ($urandom_range(0, 3) != 0);
        next_toggle = issued + $urandom_range(60, 140);
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        ch = $urandom_range(0, NumChannels - 1);
        if ($urandom_range(0, 19) == 0) begin
          send_command(FUNC_CLEAR, ChanW'($urandom_range(0, 7)), AdcBits'($urandom),
                       pick_cmd_gap());
          issued++;
        end
        repeat ($urandom_range(0, 3)) begin
          send_command(FUNC_LEARN, ChanW'(ch), rand_sample(), pick_cmd_gap());
          issued++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_command(FUNC_CONVERT, ChanW'(ch), rand_sample(), pick_cmd_gap());
          issued++;
        end
      end else if (r < 93) begin
        send_command(FuncW'($urandom_range(1, 3)), ChanW'($urandom_range(NumChannels, 7)),
                     AdcBits'($urandom), pick_cmd_gap());
      end else if (r < 97) begin
        send_command(FuncSpare, ChanW'($urandom_range(0, 7)), AdcBits'($urandom),
                     pick_cmd_gap());
      end else begin
        send_command(FuncW'($urandom_range(0, 2)), ChanW'($urandom_range(0, NumChannels - 1)),
                     AdcBits'($urandom), pick_cmd_gap());
        issued++;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    int n;
    conv_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        n = hold_off_req;
        hold_off_req = 0;
        conv_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (ready_gap > 0) begin
        conv_if.ready = 1'b0;
        ready_gap--;
      end else begin
        conv_if.ready = 1'b1;
        if (conv_idle_on && $urandom_range(0, 99) < 25) ready_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    conversion_t want;
    if (rst_n === 1'b1 && conv_if.valid === 1'b1 && conv_if.ready === 1'b1) begin
      if (expected_conversions.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxLoggedMismatches)
          $display("Unexpected beat: pct %0d deg %0b lo %0d hi %0d", conv_if.percent,
                   conv_if.degenerate, conv_if.low_bound, conv_if.high_bound);
      end else begin
        want = expected_conversions.pop_front();
        if (conv_if.percent !== want.percent || conv_if.degenerate !== want.degenerate ||
            conv_if.low_bound !== want.low_bound || conv_if.high_bound !== want.high_bound)
        begin
          mismatches++;
          if (mismatches <= MaxLoggedMismatches) begin
            $write("Mismatch: expected pct %0d deg %0b lo %0d hi %0d, ", want.percent,
                   want.degenerate, want.low_bound, want.high_bound);
            $display("got pct %0d deg %0b lo %0d hi %0d", conv_if.percent,
                     conv_if.degenerate, conv_if.low_bound, conv_if.high_bound);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (conv_if.valid === 1'b1 && conv_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.func = FUNC_CLEAR;
    cmd_if.channel = '0;
    cmd_if.sample = '0;
    foreach (learned_min[i]) begin
      learned_min[i] = '0;
      learned_max[i] = StoreW'(AdcTop);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_bounds();
    test_clear_and_scaling();
    test_ignored_commands();
    test_output_backpressure();
    test_random_commands();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/acs_pkg.sv
rtl/core/acs_in_if.sv
rtl/core/acs_out_if.sv
rtl/core/acs_front.sv
rtl/core/acs_back.sv
rtl/core/adc_range_calibrate_scale.sv
rtl/core/acs_checker.sv
verif/testbench.sv
